/* hdl/cae_pkg.sv */
`default_nettype none
package cae_pkg;

    localparam int LEVEL_FRAC_BITS = 24;
    localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << LEVEL_FRAC_BITS;

    localparam logic [15:0] CURVE_UNIT = 16'd4096;
    localparam logic [15:0] CURVE_MIN = 16'd410;
    localparam logic [15:0] CURVE_MAX = 16'd40960;
    localparam logic [15:0] CURVE_LIN_LO = 16'd4092;
    localparam logic [15:0] CURVE_LIN_HI = 16'd4100;

    localparam logic [4:0] DIV_LAST = 5'd23;
    localparam logic [4:0] LOG_LAST = 5'd15;
    localparam logic [4:0] EXP_LAST = 5'd15;
    localparam logic [4:0] ROOT_STEP_LAST = 5'd29;
    localparam logic [3:0] ROOT_LAST = 4'd15;

    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_NOTE_ON = 2'd1;
    localparam logic [1:0] FUNC_NOTE_OFF = 2'd2;
    localparam logic [1:0] FUNC_RESET = 2'd3;

    localparam logic [2:0] REG_ATTACK_STEP = 3'd0;
    localparam logic [2:0] REG_DECAY_STEP = 3'd1;
    localparam logic [2:0] REG_RELEASE_STEP = 3'd2;
    localparam logic [2:0] REG_SUSTAIN_LEVEL = 3'd3;
    localparam logic [2:0] REG_ATTACK_CURVE = 3'd4;
    localparam logic [2:0] REG_DECAY_CURVE = 3'd5;
    localparam logic [2:0] REG_RELEASE_CURVE = 3'd6;

    typedef enum logic [2:0] {
        STG_IDLE = 3'd0,
        STG_ATTACK = 3'd1,
        STG_DECAY = 3'd2,
        STG_SUSTAIN = 3'd3,
        STG_RELEASE = 3'd4
    } stage_t;

    typedef enum logic [4:0] {
        CS_INIT_LOAD, CS_INIT_SQRT, CS_INIT_STORE, CS_IDLE, CS_EVAL, CS_ROUTE,
        CS_PDIV, CS_PFIX, CS_CURVE, CS_CROUTE, CS_EDIV, CS_EFIX, CS_POW,
        CS_PROUTE, CS_NORM, CS_LOG, CS_NLMUL, CS_EXP, CS_EXPFIN, CS_ENVMUL,
        CS_ENVFIN, CS_AUDMUL, CS_AUDFIN, CS_DONE
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_INIT_LOAD, OP_INIT_STEP, OP_INIT_STORE, OP_ACCEPT, OP_EVAL,
        OP_DIV_STEP, OP_PFIX, OP_CURVE, OP_EFIX, OP_POW, OP_NORM, OP_LOG,
        OP_NLMUL, OP_EXP, OP_EXPFIN, OP_ENVMUL, OP_ENVFIN, OP_AUDMUL,
        OP_AUDFIN, OP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic [3:0] idx;
        logic [4:0] cnt;
    } dp_cmd_t;

    typedef struct packed {
        logic env_direct;
        logic need_div;
        logic lin;
        logic inv;
        logic trivial;
        logic norm_done;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] attack_step;
        logic [LEVEL_W-1:0] decay_step;
        logic [LEVEL_W-1:0] release_step;
        logic [LEVEL_W-1:0] sustain_level;
        logic [15:0] attack_curve;
        logic [15:0] decay_curve;
        logic [15:0] release_curve;
    } cfg_t;

endpackage
`default_nettype wire

/* hdl/curved_adsr_envelope.sv */
// Curved ADSR envelope generator. After reset the block builds its table of
// sixteen 2^(-2^-i) factors with a bit-serial square root (in_ready stays
// low; register writes are taken). Note on, note off and reset words go
// straight to the output stage. A tick word in idle or sustain skips the
// curve; other ticks shape the curve, near-linear curves directly, adding a
// division for a decay or release position, another for the reciprocal
// exponent of a curve below 1, and the power chain (leading-one shifts,
// 16 log2 squaring steps, 16 exp2 product steps) for other curves. The shared
// restoring divider serves both divisions, and the log2 and exp2 loops take
// one step per cycle. One word is processed at a time; a finished result
// waits in an output register while the next word is taken.
`default_nettype none
module curved_adsr_envelope (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         func,
    input  wire logic signed [23:0] audio_in,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [24:0]             env_level,
    output logic signed [23:0]      audio_out,
    output logic [2:0]              stage,
    output logic                    active,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    cae_pkg::cfg_t       cfg;
    cae_pkg::dp_cmd_t    cmd;
    cae_pkg::dp_status_t status;

    cae_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_func  (func),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cae_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg),
        .func      (func),
        .audio_in  (audio_in),
        .out_ready (out_ready),
        .status    (status),
        .out_valid (out_valid),
        .env_level (env_level),
        .audio_out (audio_out),
        .stage     (stage),
        .active    (active)
    );

endmodule
`default_nettype wire

/* hdl/cae_regs.sv */
`default_nettype none
module cae_regs (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cae_pkg::cfg_t    cfg
);

    logic [24:0] attack_step_reg;
    logic [24:0] decay_step_reg;
    logic [24:0] release_step_reg;
    logic [24:0] sustain_level_reg;
    logic [15:0] attack_curve_reg;
    logic [15:0] decay_curve_reg;
    logic [15:0] release_curve_reg;
    logic        wr_en;
    logic [2:0]  index;

    function automatic logic [24:0] clamp_step(input logic [24:0] v);
        logic [24:0] r;
        r = v;
        if (v == 25'd0) r = 25'd1;
        else if (v > cae_pkg::LEVEL_ONE) r = cae_pkg::LEVEL_ONE;
        return r;
    endfunction

    function automatic logic [15:0] clamp_curve(input logic [15:0] v);
        logic [15:0] r;
        r = v;
        if (v < cae_pkg::CURVE_MIN) r = cae_pkg::CURVE_MIN;
        else if (v > cae_pkg::CURVE_MAX) r = cae_pkg::CURVE_MAX;
        return r;
    endfunction

    assign pready = 1'b1;
    assign index = paddr[4:2];
    assign wr_en = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_step_reg <= 25'd38043;
            decay_step_reg <= 25'd1141;
            release_step_reg <= 25'd1332;
            sustain_level_reg <= 25'd11744051;
            attack_curve_reg <= 16'd4096;
            decay_curve_reg <= 16'd4096;
            release_curve_reg <= 16'd4096;
        end
        else if (wr_en)
        begin
            case (index)
                cae_pkg::REG_ATTACK_STEP: attack_step_reg <= pwdata[24:0];
                cae_pkg::REG_DECAY_STEP: decay_step_reg <= pwdata[24:0];
                cae_pkg::REG_RELEASE_STEP: release_step_reg <= pwdata[24:0];
                cae_pkg::REG_SUSTAIN_LEVEL: sustain_level_reg <= pwdata[24:0];
                cae_pkg::REG_ATTACK_CURVE: attack_curve_reg <= pwdata[15:0];
                cae_pkg::REG_DECAY_CURVE: decay_curve_reg <= pwdata[15:0];
                cae_pkg::REG_RELEASE_CURVE: release_curve_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            cae_pkg::REG_ATTACK_STEP: prdata = {7'd0, attack_step_reg};
            cae_pkg::REG_DECAY_STEP: prdata = {7'd0, decay_step_reg};
            cae_pkg::REG_RELEASE_STEP: prdata = {7'd0, release_step_reg};
            cae_pkg::REG_SUSTAIN_LEVEL: prdata = {7'd0, sustain_level_reg};
            cae_pkg::REG_ATTACK_CURVE: prdata = {16'd0, attack_curve_reg};
            cae_pkg::REG_DECAY_CURVE: prdata = {16'd0, decay_curve_reg};
            cae_pkg::REG_RELEASE_CURVE: prdata = {16'd0, release_curve_reg};
            default: prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        cfg.attack_step = clamp_step(attack_step_reg);
        cfg.decay_step = clamp_step(decay_step_reg);
        cfg.release_step = clamp_step(release_step_reg);
        cfg.sustain_level = (sustain_level_reg > cae_pkg::LEVEL_ONE) ?
                            cae_pkg::LEVEL_ONE : sustain_level_reg;
        cfg.attack_curve = clamp_curve(attack_curve_reg);
        cfg.decay_curve = clamp_curve(decay_curve_reg);
        cfg.release_curve = clamp_curve(release_curve_reg);
    end

endmodule
`default_nettype wire

/* hdl/cae_ctrl.sv */
`default_nettype none
module cae_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [1:0]          in_func,
    output logic                     in_ready,
    input  cae_pkg::dp_status_t      status,
    output cae_pkg::dp_cmd_t         cmd
);

    cae_pkg::ctrl_state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [3:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cae_pkg::CS_INIT_LOAD;
            cnt_reg <= 5'd0;
            idx_reg <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        case (state_reg)
            cae_pkg::CS_INIT_LOAD:
            begin
                state_next = cae_pkg::CS_INIT_SQRT;
                cnt_next = 5'd0;
            end
            cae_pkg::CS_INIT_SQRT:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == cae_pkg::ROOT_STEP_LAST) state_next = cae_pkg::CS_INIT_STORE;
            end
            cae_pkg::CS_INIT_STORE:
            begin
                idx_next = idx_reg + 4'd1;
                if (idx_reg == cae_pkg::ROOT_LAST) state_next = cae_pkg::CS_IDLE;
                else state_next = cae_pkg::CS_INIT_LOAD;
            end
            cae_pkg::CS_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_func == cae_pkg::FUNC_TICK) state_next = cae_pkg::CS_EVAL;
                    else state_next = cae_pkg::CS_DONE;
                end
            end
            cae_pkg::CS_EVAL: state_next = cae_pkg::CS_ROUTE;
            cae_pkg::CS_ROUTE:
            begin
                cnt_next = 5'd0;
                if (status.env_direct) state_next = cae_pkg::CS_AUDMUL;
                else if (status.need_div) state_next = cae_pkg::CS_PDIV;
                else state_next = cae_pkg::CS_CURVE;
            end
            cae_pkg::CS_PDIV:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == cae_pkg::DIV_LAST) state_next = cae_pkg::CS_PFIX;
            end
            cae_pkg::CS_PFIX: state_next = cae_pkg::CS_CURVE;
            cae_pkg::CS_CURVE: state_next = cae_pkg::CS_CROUTE;
            cae_pkg::CS_CROUTE:
            begin
                cnt_next = 5'd0;
                if (status.lin) state_next = cae_pkg::CS_ENVMUL;
                else if (status.inv) state_next = cae_pkg::CS_EDIV;
                else state_next = cae_pkg::CS_POW;
            end
            cae_pkg::CS_EDIV:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == cae_pkg::DIV_LAST) state_next = cae_pkg::CS_EFIX;
            end
            cae_pkg::CS_EFIX: state_next = cae_pkg::CS_POW;
            cae_pkg::CS_POW: state_next = cae_pkg::CS_PROUTE;
            cae_pkg::CS_PROUTE:
            begin
                if (status.trivial) state_next = cae_pkg::CS_ENVMUL;
                else state_next = cae_pkg::CS_NORM;
            end
            cae_pkg::CS_NORM:
            begin
                cnt_next = 5'd0;
                if (status.norm_done) state_next = cae_pkg::CS_LOG;
            end
            cae_pkg::CS_LOG:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == cae_pkg::LOG_LAST) state_next = cae_pkg::CS_NLMUL;
            end
            cae_pkg::CS_NLMUL:
            begin
                cnt_next = 5'd0;
                state_next = cae_pkg::CS_EXP;
            end
            cae_pkg::CS_EXP:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == cae_pkg::EXP_LAST) state_next = cae_pkg::CS_EXPFIN;
            end
            cae_pkg::CS_EXPFIN: state_next = cae_pkg::CS_ENVMUL;
            cae_pkg::CS_ENVMUL: state_next = cae_pkg::CS_ENVFIN;
            cae_pkg::CS_ENVFIN: state_next = cae_pkg::CS_AUDMUL;
            cae_pkg::CS_AUDMUL: state_next = cae_pkg::CS_AUDFIN;
            cae_pkg::CS_AUDFIN: state_next = cae_pkg::CS_DONE;
            cae_pkg::CS_DONE:
            begin
                if (status.out_free) state_next = cae_pkg::CS_IDLE;
            end
            default: state_next = cae_pkg::CS_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.op = cae_pkg::OP_NONE;
        cmd.idx = idx_reg;
        cmd.cnt = cnt_reg;
        case (state_reg)
            cae_pkg::CS_INIT_LOAD: cmd.op = cae_pkg::OP_INIT_LOAD;
            cae_pkg::CS_INIT_SQRT: cmd.op = cae_pkg::OP_INIT_STEP;
            cae_pkg::CS_INIT_STORE: cmd.op = cae_pkg::OP_INIT_STORE;
            cae_pkg::CS_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd.op = cae_pkg::OP_ACCEPT;
            end
            cae_pkg::CS_EVAL: cmd.op = cae_pkg::OP_EVAL;
            cae_pkg::CS_PDIV: cmd.op = cae_pkg::OP_DIV_STEP;
            cae_pkg::CS_PFIX: cmd.op = cae_pkg::OP_PFIX;
            cae_pkg::CS_CURVE: cmd.op = cae_pkg::OP_CURVE;
            cae_pkg::CS_EDIV: cmd.op = cae_pkg::OP_DIV_STEP;
            cae_pkg::CS_EFIX: cmd.op = cae_pkg::OP_EFIX;
            cae_pkg::CS_POW: cmd.op = cae_pkg::OP_POW;
            cae_pkg::CS_NORM:
            begin
                if (!status.norm_done) cmd.op = cae_pkg::OP_NORM;
            end
            cae_pkg::CS_LOG: cmd.op = cae_pkg::OP_LOG;
            cae_pkg::CS_NLMUL: cmd.op = cae_pkg::OP_NLMUL;
            cae_pkg::CS_EXP: cmd.op = cae_pkg::OP_EXP;
            cae_pkg::CS_EXPFIN: cmd.op = cae_pkg::OP_EXPFIN;
            cae_pkg::CS_ENVMUL: cmd.op = cae_pkg::OP_ENVMUL;
            cae_pkg::CS_ENVFIN: cmd.op = cae_pkg::OP_ENVFIN;
            cae_pkg::CS_AUDMUL: cmd.op = cae_pkg::OP_AUDMUL;
            cae_pkg::CS_AUDFIN: cmd.op = cae_pkg::OP_AUDFIN;
            cae_pkg::CS_DONE:
            begin
                if (status.out_free) cmd.op = cae_pkg::OP_LOAD_OUT;
            end
            default: cmd.op = cae_pkg::OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

/* hdl/cae_dp.sv */
`default_nettype none
module cae_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  cae_pkg::dp_cmd_t        cmd,
    input  cae_pkg::cfg_t           cfg,
    input  wire logic [1:0]         func,
    input  wire logic signed [23:0] audio_in,
    input  wire logic               out_ready,
    output cae_pkg::dp_status_t     status,
    output logic                    out_valid,
    output logic [24:0]             env_level,
    output logic signed [23:0]      audio_out,
    output logic [2:0]              stage,
    output logic                    active
);

    localparam logic [24:0] ONE = cae_pkg::LEVEL_ONE;

    cae_pkg::stage_t stage_reg, stage_next;
    logic [24:0] level_reg, level_next;
    logic [24:0] start_reg, start_next;

    logic [29:0] root_mem [16];
    logic [29:0] root_rd_reg;
    logic [59:0] sq_n_reg, sq_n_next;
    logic [59:0] sq_res_reg, sq_res_next;

    logic [23:0] audio_reg, audio_next;
    logic        direct_reg, direct_next;
    logic        need_div_reg, need_div_next;
    logic        psub_reg, psub_next;
    logic        attack_reg, attack_next;
    logic [24:0] base_reg, base_next;
    logic [24:0] scale_reg, scale_next;
    logic [24:0] p_reg, p_next;
    logic [24:0] rem_reg, rem_next;
    logic [24:0] div_reg, div_next;
    logic [23:0] quo_reg, quo_next;
    logic [15:0] c_reg, c_next;
    logic [24:0] x_reg, x_next;
    logic [15:0] e_reg, e_next;
    logic        lin_reg, lin_next;
    logic        inv_reg, inv_next;
    logic        trivial_reg, trivial_next;
    logic [31:0] m_reg, m_next;
    logic [4:0]  k_reg, k_next;
    logic [15:0] frac_reg, frac_next;
    logic [24:0] t_reg, t_next;
    logic [30:0] acc_reg, acc_next;
    logic [24:0] sh_reg, sh_next;
    logic [24:0] prod_reg, prod_next;
    logic [24:0] env_reg, env_next;
    logic [23:0] q_reg, q_next;
    logic [23:0] aout_reg, aout_next;

    logic        out_valid_reg, out_valid_next;
    logic [24:0] env_out_reg, env_out_next;
    logic [23:0] aout_out_reg, aout_out_next;
    logic [2:0]  stage_out_reg, stage_out_next;

    logic [3:0]  root_addr;
    logic [59:0] sq_bit;
    logic [60:0] sq_sum;
    logic signed [25:0] lvl_s;
    logic signed [25:0] l_dec;
    logic signed [25:0] l_rel;
    logic [25:0] num;
    logic [24:0] oms;
    logic [25:0] lvl_sum;
    logic [25:0] r2;
    logic [63:0] sqr;
    logic [21:0] nl;
    logic [37:0] nl_prod;
    logic [60:0] acc_prod;
    logic [24:0] a6;
    logic [24:0] pow_r;
    logic [49:0] env_prod;
    logic [24:0] mag;
    logic [49:0] aud_prod;

    // fetch the factor for the next exp2 step ahead of its use through the registered read
    assign root_addr = (cmd.op == cae_pkg::OP_EXP) ? (cmd.cnt[3:0] + 4'd1) : 4'd0;

    always_ff @(posedge clk)
    begin
        if (cmd.op == cae_pkg::OP_INIT_STORE)
        begin
            root_mem[cmd.idx] <= sq_res_reg[29:0];
        end
        root_rd_reg <= root_mem[root_addr];
    end

    always_comb
    begin
        sq_bit = 60'd1 << (6'd58 - {cmd.cnt, 1'b0});
        sq_sum = {1'b0, sq_res_reg} + {1'b0, sq_bit};
        lvl_s = $signed({1'b0, level_reg});
        l_dec = lvl_s - $signed({1'b0, cfg.decay_step});
        l_rel = lvl_s - $signed({1'b0, cfg.release_step});
        oms = ONE - cfg.sustain_level;
        num = {1'b0, ONE} - 26'(l_dec);
        lvl_sum = {1'b0, level_reg} + {1'b0, cfg.attack_step};
        r2 = {rem_reg, 1'b0};
        sqr = 64'(m_reg) * 64'(m_reg);
        nl = {6'd32 - {1'b0, k_reg}, 16'd0} - {6'd0, frac_reg};
        nl_prod = 38'(nl) * 38'(e_reg);
        acc_prod = 61'(acc_reg) * 61'(root_rd_reg);
        a6 = acc_reg[30:6];
        pow_r = a6 >> t_reg[24:16];
        if (pow_r > ONE) pow_r = ONE;
        env_prod = 50'(scale_reg) * 50'(sh_reg);
        mag = audio_reg[23] ? (ONE - {1'b0, audio_reg}) : {1'b0, audio_reg};
        aud_prod = 50'(mag) * 50'(env_reg);
    end

    always_comb
    begin
        stage_next = stage_reg;
        level_next = level_reg;
        start_next = start_reg;
        sq_n_next = sq_n_reg;
        sq_res_next = sq_res_reg;
        audio_next = audio_reg;
        direct_next = direct_reg;
        need_div_next = need_div_reg;
        psub_next = psub_reg;
        attack_next = attack_reg;
        base_next = base_reg;
        scale_next = scale_reg;
        p_next = p_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        quo_next = quo_reg;
        c_next = c_reg;
        x_next = x_reg;
        e_next = e_reg;
        lin_next = lin_reg;
        inv_next = inv_reg;
        trivial_next = trivial_reg;
        m_next = m_reg;
        k_next = k_reg;
        frac_next = frac_reg;
        t_next = t_reg;
        acc_next = acc_reg;
        sh_next = sh_reg;
        prod_next = prod_reg;
        env_next = env_reg;
        q_next = q_reg;
        aout_next = aout_reg;
        out_valid_next = out_valid_reg && !out_ready;
        env_out_next = env_out_reg;
        aout_out_next = aout_out_reg;
        stage_out_next = stage_out_reg;
        case (cmd.op)
            cae_pkg::OP_INIT_LOAD:
            begin
                sq_n_next = (cmd.idx == 4'd0) ? (60'd1 << 59) : {sq_res_reg[29:0], 30'd0};
                sq_res_next = 60'd0;
            end
            cae_pkg::OP_INIT_STEP:
            begin
                if ({1'b0, sq_n_reg} >= sq_sum)
                begin
                    sq_n_next = sq_n_reg - sq_sum[59:0];
                    sq_res_next = (sq_res_reg >> 1) + sq_bit;
                end
                else
                begin
                    sq_res_next = sq_res_reg >> 1;
                end
            end
            cae_pkg::OP_ACCEPT:
            begin
                audio_next = audio_in;
                env_next = 25'd0;
                aout_next = 24'd0;
                case (func)
                    cae_pkg::FUNC_NOTE_ON:
                    begin
                        stage_next = cae_pkg::STG_ATTACK;
                        start_next = 25'd0;
                    end
                    cae_pkg::FUNC_NOTE_OFF:
                    begin
                        if (stage_reg != cae_pkg::STG_IDLE &&
                            stage_reg != cae_pkg::STG_RELEASE)
                        begin
                            start_next = level_reg;
                            stage_next = cae_pkg::STG_RELEASE;
                        end
                    end
                    cae_pkg::FUNC_RESET:
                    begin
                        stage_next = cae_pkg::STG_IDLE;
                        level_next = 25'd0;
                        start_next = 25'd0;
                    end
                    default: ;
                endcase
            end
            cae_pkg::OP_EVAL:
            begin
                direct_next = 1'b0;
                need_div_next = 1'b0;
                psub_next = 1'b0;
                attack_next = 1'b0;
                case (stage_reg)
                    cae_pkg::STG_ATTACK:
                    begin
                        attack_next = 1'b1;
                        c_next = cfg.attack_curve;
                        if (lvl_sum >= {1'b0, ONE})
                        begin
                            p_next = ONE;
                            level_next = ONE;
                            stage_next = cae_pkg::STG_DECAY;
                        end
                        else
                        begin
                            p_next = lvl_sum[24:0];
                            level_next = lvl_sum[24:0];
                        end
                    end
                    cae_pkg::STG_DECAY:
                    begin
                        c_next = cfg.decay_curve;
                        base_next = ONE;
                        scale_next = oms;
                        if (cfg.sustain_level >= ONE) p_next = ONE;
                        else if (l_dec >= $signed({1'b0, ONE})) p_next = 25'd0;
                        else if (num >= {1'b0, oms}) p_next = ONE;
                        else
                        begin
                            need_div_next = 1'b1;
                            rem_next = num[24:0];
                            div_next = oms;
                        end
                        if (l_dec <= $signed({1'b0, cfg.sustain_level}))
                        begin
                            level_next = cfg.sustain_level;
                            stage_next = cae_pkg::STG_SUSTAIN;
                        end
                        else
                        begin
                            level_next = l_dec[24:0];
                        end
                    end
                    cae_pkg::STG_SUSTAIN:
                    begin
                        direct_next = 1'b1;
                        level_next = cfg.sustain_level;
                        env_next = cfg.sustain_level;
                    end
                    cae_pkg::STG_RELEASE:
                    begin
                        c_next = cfg.release_curve;
                        base_next = start_reg;
                        scale_next = start_reg;
                        psub_next = 1'b1;
                        if (start_reg == 25'd0 || l_rel <= 26'sd0) p_next = ONE;
                        else if (l_rel[24:0] >= start_reg) p_next = 25'd0;
                        else
                        begin
                            need_div_next = 1'b1;
                            rem_next = l_rel[24:0];
                            div_next = start_reg;
                        end
                        if (l_rel <= 26'sd0)
                        begin
                            level_next = 25'd0;
                            stage_next = cae_pkg::STG_IDLE;
                        end
                        else
                        begin
                            level_next = l_rel[24:0];
                        end
                    end
                    default:
                    begin
                        direct_next = 1'b1;
                        env_next = 25'd0;
                    end
                endcase
            end
            cae_pkg::OP_DIV_STEP:
            begin
                if (r2 >= {1'b0, div_reg})
                begin
                    rem_next = 25'(r2 - {1'b0, div_reg});
                    quo_next = {quo_reg[22:0], 1'b1};
                end
                else
                begin
                    rem_next = r2[24:0];
                    quo_next = {quo_reg[22:0], 1'b0};
                end
            end
            cae_pkg::OP_PFIX:
            begin
                p_next = psub_reg ? (ONE - {1'b0, quo_reg}) : {1'b0, quo_reg};
            end
            cae_pkg::OP_CURVE:
            begin
                lin_next = 1'b0;
                inv_next = 1'b0;
                if (c_reg >= cae_pkg::CURVE_LIN_LO && c_reg <= cae_pkg::CURVE_LIN_HI)
                begin
                    lin_next = 1'b1;
                    sh_next = p_reg;
                end
                else if (c_reg > cae_pkg::CURVE_UNIT)
                begin
                    x_next = p_reg;
                    e_next = c_reg;
                end
                else
                begin
                    inv_next = 1'b1;
                    x_next = ONE - p_reg;
                    rem_next = 25'd1;
                    div_next = {9'd0, c_reg};
                end
            end
            cae_pkg::OP_EFIX:
            begin
                e_next = quo_reg[15:0];
            end
            cae_pkg::OP_POW:
            begin
                trivial_next = 1'b1;
                if (x_reg == 25'd0) sh_next = inv_reg ? ONE : 25'd0;
                else if (x_reg[24]) sh_next = inv_reg ? 25'd0 : ONE;
                else
                begin
                    trivial_next = 1'b0;
                    m_next = {x_reg[23:0], 8'd0};
                    k_next = 5'd31;
                end
            end
            cae_pkg::OP_NORM:
            begin
                m_next = {m_reg[30:0], 1'b0};
                k_next = k_reg - 5'd1;
            end
            cae_pkg::OP_LOG:
            begin
                if (sqr[63])
                begin
                    m_next = sqr[63:32];
                    frac_next = {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    m_next = sqr[62:31];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
            end
            cae_pkg::OP_NLMUL:
            begin
                t_next = nl_prod[36:12];
                acc_next = 31'd1 << 30;
            end
            cae_pkg::OP_EXP:
            begin
                if (t_reg[4'd15 - cmd.cnt[3:0]]) acc_next = acc_prod[60:30];
            end
            cae_pkg::OP_EXPFIN:
            begin
                sh_next = inv_reg ? (ONE - pow_r) : pow_r;
            end
            cae_pkg::OP_ENVMUL:
            begin
                prod_next = sh_reg[24] ? scale_reg : env_prod[48:24];
            end
            cae_pkg::OP_ENVFIN:
            begin
                env_next = attack_reg ? sh_reg : (base_reg - prod_reg);
            end
            cae_pkg::OP_AUDMUL:
            begin
                q_next = env_reg[24] ? mag[23:0] : aud_prod[47:24];
            end
            cae_pkg::OP_AUDFIN:
            begin
                aout_next = audio_reg[23] ? (24'd0 - q_reg) : q_reg;
            end
            cae_pkg::OP_LOAD_OUT:
            begin
                out_valid_next = 1'b1;
                env_out_next = env_reg;
                aout_out_next = aout_reg;
                stage_out_next = stage_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= cae_pkg::STG_IDLE;
            level_reg <= 25'd0;
            start_reg <= 25'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
            level_reg <= level_next;
            start_reg <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_n_reg <= sq_n_next;
        sq_res_reg <= sq_res_next;
        audio_reg <= audio_next;
        direct_reg <= direct_next;
        need_div_reg <= need_div_next;
        psub_reg <= psub_next;
        attack_reg <= attack_next;
        base_reg <= base_next;
        scale_reg <= scale_next;
        p_reg <= p_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
        c_reg <= c_next;
        x_reg <= x_next;
        e_reg <= e_next;
        lin_reg <= lin_next;
        inv_reg <= inv_next;
        trivial_reg <= trivial_next;
        m_reg <= m_next;
        k_reg <= k_next;
        frac_reg <= frac_next;
        t_reg <= t_next;
        acc_reg <= acc_next;
        sh_reg <= sh_next;
        prod_reg <= prod_next;
        env_reg <= env_next;
        q_reg <= q_next;
        aout_reg <= aout_next;
        env_out_reg <= env_out_next;
        aout_out_reg <= aout_out_next;
        stage_out_reg <= stage_out_next;
    end

    assign status.env_direct = direct_reg;
    assign status.need_div = need_div_reg;
    assign status.lin = lin_reg;
    assign status.inv = inv_reg;
    assign status.trivial = trivial_reg;
    assign status.norm_done = m_reg[31];
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign env_level = env_out_reg;
    assign audio_out = aout_out_reg;
    assign stage = stage_out_reg;
    assign active = (stage_out_reg != cae_pkg::STG_IDLE);

`ifndef NO_ASSERTIONS
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= ONE)
        else $error("linear level above full scale");
    a_shape_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == cae_pkg::OP_ENVMUL |-> sh_reg <= ONE)
        else $error("shaped position above full scale");
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == cae_pkg::OP_LOAD_OUT |=> out_valid_reg)
        else $error("result word not presented after load");
    a_start_release: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == cae_pkg::OP_ACCEPT && func == cae_pkg::FUNC_NOTE_ON |=> start_reg == 25'd0)
        else $error("release start not cleared on note on");
`endif

endmodule
`default_nettype wire

/* dv/curved_adsr_checker.sv */
`timescale 1ns / 100ps
`default_nettype none
module curved_adsr_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [1:0]         func,
    input  wire logic signed [23:0] audio_in,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [24:0]        env_level,
    input  wire logic signed [23:0] audio_out,
    input  wire logic [2:0]         stage,
    input  wire logic               active,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic               pready,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output int                      fail_count,
    output int                      pending
);

    typedef logic [63:0] u64;

    localparam u64 ONE = u64'(1) << cae_pkg::LEVEL_FRAC_BITS;

    typedef struct packed {
        logic [24:0]     env;
        logic [23:0]     aud;
        cae_pkg::stage_t stg;
        logic            act;
    } env_word_t;

    env_word_t env_q[$];

    logic [24:0]     attack_step, decay_step, release_step, sustain_lvl;
    logic [15:0]     attack_crv, decay_crv, release_crv;
    cae_pkg::stage_t cur_stage;
    u64              level, rel_start;

    function automatic u64 clamp(u64 v, u64 lo, u64 hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic u64 frac_mul(u64 a, u64 b);
        if (b >= ONE)
            return a;
        return (a * b) >> cae_pkg::LEVEL_FRAC_BITS;
    endfunction

    function automatic u64 root_floor(u64 n);
        u64 r;
        u64 b;
        r = 0;
        b = u64'(1) << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - r - b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic u64 exp2_neg(u64 t);
        u64 ip;
        u64 f;
        u64 acc;
        u64 v;
        ip = t >> 16;
        f = t & 64'hFFFF;
        acc = u64'(1) << 30;
        v = 0;
        for (int i = 1; i <= 16; i++)
        begin
            v = (i == 1) ? root_floor(u64'(1) << 59) : root_floor(v << 30);
            if (f[16-i])
                acc = (acc * v) >> 30;
        end
        acc >>= (30 - cae_pkg::LEVEL_FRAC_BITS);
        if (ip >= 63)
            return 0;
        acc >>= ip;
        return acc > ONE ? ONE : acc;
    endfunction

    function automatic u64 power(u64 x, u64 e);
        u64 x32;
        u64 m;
        u64 frac;
        u64 nl;
        int k;
        if (x == 0)
            return 0;
        if (x >= ONE)
            return ONE;
        x32 = x << (32 - cae_pkg::LEVEL_FRAC_BITS);
        k = 31;
        while (k > 0 && x32[k] == 1'b0)
            k--;
        m = x32 << (31 - k);
        frac = 0;
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 31;
            frac <<= 1;
            if (m >= (u64'(1) << 32))
            begin
                frac |= 1;
                m >>= 1;
            end
        end
        nl = (u64'(32 - k) << 16) - frac;
        return exp2_neg((nl * e) >> 12);
    endfunction

    function automatic u64 curve(u64 p, u64 c);
        if (p > ONE)
            p = ONE;
        if (c + 4 >= cae_pkg::CURVE_UNIT && c <= cae_pkg::CURVE_UNIT + 4)
            return p;
        if (c > cae_pkg::CURVE_UNIT)
            return power(p, c);
        return ONE - power(ONE - p,
                           (u64'(cae_pkg::CURVE_UNIT) * cae_pkg::CURVE_UNIT) / c);
    endfunction

    function automatic u64 advance_level();
        u64     s;
        u64     p;
        u64     env;
        u64     num;
        longint l;
        s = clamp(sustain_lvl, 0, ONE);
        case (cur_stage)
            cae_pkg::STG_ATTACK:
            begin
                level = level + clamp(attack_step, 1, ONE);
                env = curve(level, clamp(attack_crv, cae_pkg::CURVE_MIN, cae_pkg::CURVE_MAX));
                if (level >= ONE)
                begin
                    level = ONE;
                    cur_stage = cae_pkg::STG_DECAY;
                end
                return env;
            end
            cae_pkg::STG_DECAY:
            begin
                l = longint'(level) - longint'(clamp(decay_step, 1, ONE));
                if (s >= ONE)
                    p = ONE;
                else if (l >= longint'(ONE))
                    p = 0;
                else
                begin
                    num = u64'(longint'(ONE) - l);
                    if (num >= ONE - s)
                        p = ONE;
                    else
                        p = (num << cae_pkg::LEVEL_FRAC_BITS) / (ONE - s);
                end
                env = ONE - frac_mul(ONE - s,
                      curve(p, clamp(decay_crv, cae_pkg::CURVE_MIN, cae_pkg::CURVE_MAX)));
                if (l <= longint'(s))
                begin
                    level = s;
                    cur_stage = cae_pkg::STG_SUSTAIN;
                end
                else
                    level = u64'(l);
                return env;
            end
            cae_pkg::STG_SUSTAIN:
            begin
                level = s;
                return s;
            end
            cae_pkg::STG_RELEASE:
            begin
                l = longint'(level) - longint'(clamp(release_step, 1, ONE));
                if (rel_start == 0 || l <= 0)
                    p = ONE;
                else if (u64'(l) >= rel_start)
                    p = 0;
                else
                    p = ONE - ((u64'(l) << cae_pkg::LEVEL_FRAC_BITS) / rel_start);
                env = rel_start - frac_mul(rel_start,
                      curve(p, clamp(release_crv, cae_pkg::CURVE_MIN, cae_pkg::CURVE_MAX)));
                if (l <= 0)
                begin
                    level = 0;
                    cur_stage = cae_pkg::STG_IDLE;
                end
                else
                    level = u64'(l);
                return env;
            end
            default:
                return 0;
        endcase
    endfunction

    function automatic env_word_t predict_word(logic [1:0] f, logic [23:0] a);
        env_word_t w;
        u64        env;
        u64        mag;
        u64        q;
        env = 0;
        q = 0;
        case (f)
            cae_pkg::FUNC_TICK:
            begin
                env = advance_level();
                mag = a[23] ? (u64'(1) << 24) - u64'(a) : u64'(a);
                q = frac_mul(mag, env);
                if (a[23])
                    q = -q;
            end
            cae_pkg::FUNC_NOTE_ON:
            begin
                cur_stage = cae_pkg::STG_ATTACK;
                rel_start = 0;
            end
            cae_pkg::FUNC_NOTE_OFF:
            begin
                if (cur_stage != cae_pkg::STG_IDLE && cur_stage != cae_pkg::STG_RELEASE)
                begin
                    rel_start = level;
                    cur_stage = cae_pkg::STG_RELEASE;
                end
            end
            default:
            begin
                cur_stage = cae_pkg::STG_IDLE;
                level = 0;
                rel_start = 0;
            end
        endcase
        w.env = env[24:0];
        w.aud = q[23:0];
        w.stg = cur_stage;
        w.act = cur_stage != cae_pkg::STG_IDLE;
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        env_word_t want;
        if (!rst_n)
        begin
            attack_step <= 25'd38043;
            decay_step <= 25'd1141;
            release_step <= 25'd1332;
            sustain_lvl <= 25'd11744051;
            attack_crv <= cae_pkg::CURVE_UNIT;
            decay_crv <= cae_pkg::CURVE_UNIT;
            release_crv <= cae_pkg::CURVE_UNIT;
            cur_stage = cae_pkg::STG_IDLE;
            level = 0;
            rel_start = 0;
            env_q.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    cae_pkg::REG_ATTACK_STEP:   attack_step <= pwdata[24:0];
                    cae_pkg::REG_DECAY_STEP:    decay_step <= pwdata[24:0];
                    cae_pkg::REG_RELEASE_STEP:  release_step <= pwdata[24:0];
                    cae_pkg::REG_SUSTAIN_LEVEL: sustain_lvl <= pwdata[24:0];
                    cae_pkg::REG_ATTACK_CURVE:  attack_crv <= pwdata[15:0];
                    cae_pkg::REG_DECAY_CURVE:   decay_crv <= pwdata[15:0];
                    cae_pkg::REG_RELEASE_CURVE: release_crv <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (env_q.size() == 0)
                begin
                    $error("unexpected output word");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = env_q.pop_front();
                    if (want.env !== env_level || want.aud !== audio_out ||
                        want.stg !== stage || want.act !== active)
                        fail_count <= fail_count + 1;
                    if (want.env !== env_level)
                        $error("env_level expected %0d got %0d", want.env, env_level);
                    if (want.aud !== audio_out)
                        $error("audio_out expected %0d got %0d",
                               $signed(want.aud), audio_out);
                    if (want.stg !== stage)
                        $error("stage expected %0d got %0d", want.stg, stage);
                    if (want.act !== active)
                        $error("active expected %0d got %0d", want.act, active);
                end
            end
            if (in_valid && in_ready)
                env_q.push_back(predict_word(func, audio_in));
            pending <= env_q.size();
        end
    end

endmodule
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 100ps
`default_nettype none
module testbench;

    localparam int TIMEOUT = 20000;
    localparam int SETTLE = 300;
    localparam int HOLD_LEN = 3000;
    localparam logic [31:0] ONE = 32'h100_0000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         func = cae_pkg::FUNC_TICK;
    logic signed [23:0] audio_in = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [24:0]        env_level;
    logic signed [23:0] audio_out;
    logic [2:0]         stage;
    logic               active;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int hold_cycles = 0;
    int words_sent = 0;
    int quiet_cycles = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    curved_adsr_envelope u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .func(func), .audio_in(audio_in),
        .out_valid(out_valid), .out_ready(out_ready), .env_level(env_level),
        .audio_out(audio_out), .stage(stage), .active(active),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    curved_adsr_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .func(func), .audio_in(audio_in),
        .out_valid(out_valid), .out_ready(out_ready), .env_level(env_level),
        .audio_out(audio_out), .stage(stage), .active(active),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
    );

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (hold_req && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_cycles <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= TIMEOUT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_word(logic [1:0] f, logic [23:0] a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        audio_in <= a;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        words_sent++;
    endtask

    task automatic send_tick();
        send_word(cae_pkg::FUNC_TICK, 24'($urandom));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic load_config(int kind);
        logic [31:0] c;
        case (kind)
            0:
            begin
                reg_write(cae_pkg::REG_ATTACK_STEP, 32'hFFFF_FFFF);
                reg_write(cae_pkg::REG_DECAY_STEP, ONE);
                reg_write(cae_pkg::REG_RELEASE_STEP, 32'hFFFF_FFFF);
                reg_write(cae_pkg::REG_SUSTAIN_LEVEL, ONE);
                reg_write(cae_pkg::REG_ATTACK_CURVE, 32'hFFFF_FFFF);
                reg_write(cae_pkg::REG_DECAY_CURVE, 32'(cae_pkg::CURVE_MAX));
                reg_write(cae_pkg::REG_RELEASE_CURVE, 32'h0);
            end
            1:
            begin
                reg_write(cae_pkg::REG_ATTACK_STEP, 32'h0);
                reg_write(cae_pkg::REG_DECAY_STEP, 32'd1);
                reg_write(cae_pkg::REG_RELEASE_STEP, 32'h0);
                reg_write(cae_pkg::REG_SUSTAIN_LEVEL, 32'h0);
                reg_write(cae_pkg::REG_ATTACK_CURVE, 32'(cae_pkg::CURVE_MIN));
                reg_write(cae_pkg::REG_DECAY_CURVE, 32'h0);
                reg_write(cae_pkg::REG_RELEASE_CURVE, 32'(cae_pkg::CURVE_MIN));
                reg_write(3'd7, $urandom);
            end
            default:
            begin
                reg_write(cae_pkg::REG_ATTACK_STEP, ONE / $urandom_range(1, 40));
                reg_write(cae_pkg::REG_DECAY_STEP, ONE / $urandom_range(1, 40));
                reg_write(cae_pkg::REG_RELEASE_STEP, ONE / $urandom_range(1, 40));
                reg_write(cae_pkg::REG_SUSTAIN_LEVEL,
                          $urandom_range(3) == 0 ? ONE : $urandom_range(ONE));
                for (int r = 0; r < 3; r++)
                begin
                    case ($urandom_range(3))
                        0: c = $urandom_range(4092, 4100);
                        1: c = $urandom_range(cae_pkg::CURVE_MIN, 4091);
                        2: c = $urandom_range(4101, cae_pkg::CURVE_MAX);
                        default: c = $urandom;
                    endcase
                    reg_write(3'(cae_pkg::REG_ATTACK_CURVE + r), c);
                end
            end
        endcase
    endtask

    task automatic run_envelopes(int quota);
        int target;
        int n;
        target = words_sent + quota;
        while (words_sent < target)
        begin
            if ($urandom_range(99) < 80)
            begin
                send_word(cae_pkg::FUNC_NOTE_ON, '0);
                n = $urandom_range(1, 40);
                repeat (n) send_tick();
                if ($urandom_range(99) < 85)
                    send_word(cae_pkg::FUNC_NOTE_OFF, '0);
                n = $urandom_range(0, 50);
                repeat (n) send_tick();
                if ($urandom_range(99) < 5)
                    send_word(cae_pkg::FUNC_RESET, '0);
            end
            else
                send_word(2'($urandom), 24'($urandom));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(cae_pkg::FUNC_NOTE_OFF, '0);
        send_word(cae_pkg::FUNC_TICK, 24'h7F_FFFF);
        send_word(cae_pkg::FUNC_NOTE_ON, '0);
        send_word(cae_pkg::FUNC_NOTE_OFF, '0);
        send_word(cae_pkg::FUNC_TICK, 24'h80_0000);
        send_word(cae_pkg::FUNC_NOTE_ON, '0);
        send_word(cae_pkg::FUNC_TICK, 24'h7F_FFFF);
        send_word(cae_pkg::FUNC_TICK, 24'h80_0000);
        send_word(cae_pkg::FUNC_TICK, 24'hFF_FFFF);
        send_word(cae_pkg::FUNC_TICK, 24'h00_0000);
        send_word(cae_pkg::FUNC_NOTE_OFF, '0);
        send_word(cae_pkg::FUNC_TICK, 24'h55_5555);
        send_word(cae_pkg::FUNC_NOTE_OFF, '0);
        send_word(cae_pkg::FUNC_TICK, 24'hAA_AAAA);
        send_word(cae_pkg::FUNC_RESET, 24'hFF_FFFF);
        drain();

        load_config(0);
        send_word(cae_pkg::FUNC_NOTE_ON, '0);
        repeat (3) send_word(cae_pkg::FUNC_TICK, 24'h7F_FFFF);
        send_word(cae_pkg::FUNC_NOTE_OFF, '0);
        repeat (2) send_word(cae_pkg::FUNC_TICK, 24'h80_0000);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            load_config(ph < 2 ? ph : 2);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            if (ph == 4)
                hold_req = 1'b1;
            run_envelopes(120);
            drain();
        end

        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
`default_nettype wire
